### hdl/dual_mode_fir_filter_macros.svh
// ----------------------------------------------------------------------------
// dual_mode_fir_filter_macros.svh
// Assertion macros shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_FIR_FILTER_MACROS_SVH
`define DUAL_MODE_FIR_FILTER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define DMF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define DMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define DMF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Widths, tap counts and Q1.15 coefficient tables of the dual-mode FIR.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 15;

    localparam int LP_TAPS = 42;
    localparam int HP_TAPS = 31;

    localparam int TAP_W    = $clog2(LP_TAPS);
    localparam int HP_IDX_W = $clog2(HP_TAPS);

    // Sample is fed to the multiplier one 4-bit digit per cycle, LSB first
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int PROD_W     = COEF_W + DIGIT_W + 1;

    // Sum of up to 42 products of 16x16 bits fits in 37 bits signed
    localparam int ACC_W = 38;

    localparam int ROUND_BIAS = (1 << COEF_FRAC_BITS) - 1;
    localparam int SAT_MAX    = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAT_MIN    = -(1 << (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    localparam t_coef LP_COEF [LP_TAPS] = '{
        -16'sd224,  -16'sd145,  -16'sd174,  -16'sd191,  -16'sd190,  -16'sd163,
        -16'sd105,  -16'sd11,    16'sd123,   16'sd297,   16'sd511,   16'sd758,
         16'sd1033,  16'sd1325,  16'sd1623,  16'sd1913,  16'sd2182,  16'sd2416,
         16'sd2604,  16'sd2734,  16'sd2802,  16'sd2802,  16'sd2734,  16'sd2604,
         16'sd2416,  16'sd2182,  16'sd1913,  16'sd1623,  16'sd1325,  16'sd1033,
         16'sd758,   16'sd511,   16'sd297,   16'sd123,  -16'sd11,   -16'sd105,
        -16'sd163,  -16'sd190,  -16'sd191,  -16'sd174,  -16'sd145,  -16'sd224
    };

    localparam t_coef HP_COEF [HP_TAPS] = '{
        -16'sd1657,  16'sd479,   16'sd568,   16'sd690,   16'sd788,   16'sd795,
         16'sd651,   16'sd327,  -16'sd185,  -16'sd865,  -16'sd1659, -16'sd2489,
        -16'sd3267, -16'sd3903, -16'sd4319,  16'sd28305,
        -16'sd4319, -16'sd3903, -16'sd3267, -16'sd2489, -16'sd1659, -16'sd865,
        -16'sd185,   16'sd327,   16'sd651,   16'sd795,   16'sd788,   16'sd690,
         16'sd568,   16'sd479,  -16'sd1657
    };

endpackage

### hdl/dual_mode_fir_filter.sv
// ----------------------------------------------------------------------------
// dual_mode_fir_filter
// Dual-mode audio FIR: 42-tap low-pass or 31-tap high-pass, digit-serial MAC.
// ----------------------------------------------------------------------------
// One signed 16-bit sample in, one filtered sample out. i_cfg_wdata picks the
// filter (0 low-pass, 1 high-pass); each filter keeps its own history, held
// newest-first in a ring of registers that rotates by one position per tap so
// the sample for the current tap always sits at the ring head. A single
// 16x4 multiplier consumes the sample one 4-bit digit per cycle, taking
// the digits of each tap in turn and then moving on to the next tap. A new
// sample is taken while the previous result still waits in the output
// register. The sum is scaled by 2^-15, truncated toward zero and
// saturated to 16 bits.
module dual_mode_fir_filter
    import dmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,     // filter_select
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,         // [15:0] mono_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata          // [15:0] filtered_sample
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [TAP_W-1:0] LP_LAST = TAP_W'(LP_TAPS - 1);
    localparam logic [TAP_W-1:0] HP_LAST = TAP_W'(HP_TAPS - 1);
    localparam logic [DIG_IDX_W-1:0] DIG_LAST = DIG_IDX_W'(NUM_DIGITS - 1);

    logic [1:0]               r_state, n_state;
    logic                     r_filter_select;
    logic                     r_sel;
    logic [TAP_W-1:0]         r_tap;
    logic [DIG_IDX_W-1:0]     r_digit;
    t_sample                  r_mpy;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    t_sample                  r_out_data;

    t_sample r_lp_ring [LP_TAPS];
    t_sample r_hp_ring [HP_TAPS];

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_last_digit;
    logic                     w_last_tap;
    logic                     w_mac_first;
    logic [TAP_W-1:0]         w_tap_last;
    t_sample                  w_head;
    t_coef                    w_coef;
    logic [DIGIT_W-1:0]       w_nib;
    logic signed [DIGIT_W:0]  w_dig;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_q;
    t_sample                  w_sat;

    assign w_accept     = s_tvalid && s_tready;
    assign w_out_free   = !r_out_valid || m_tready;
    assign w_last_digit = (r_digit == DIG_LAST);
    assign w_tap_last   = r_sel ? HP_LAST : LP_LAST;
    assign w_last_tap   = (r_tap == w_tap_last);
    assign w_mac_first  = (r_state == ST_MAC) && (r_tap == '0) && (r_digit == '0);

    // Hold off input beats while reset is applied
    assign s_tready = (r_state == ST_IDLE) && i_rst_n;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // Digit-serial multiply: first digit straight from the ring head
    always_comb begin
        w_head = r_sel ? r_hp_ring[0] : r_lp_ring[0];
        w_coef = r_sel ? HP_COEF[r_tap[HP_IDX_W-1:0]] : LP_COEF[r_tap];
        w_nib  = (r_digit == '0) ? w_head[DIGIT_W-1:0] : r_mpy[DIGIT_W-1:0];
        // top digit carries the sample sign, lower digits are unsigned
        w_dig  = w_last_digit ? {w_nib[DIGIT_W-1], w_nib} : {1'b0, w_nib};
        w_prod = w_coef * w_dig;
        w_term = ACC_W'(w_prod) <<< (DIGIT_W * int'(r_digit));
    end

    // Scale by 2^-F with truncation toward zero, then clamp
    always_comb begin
        w_rnd = r_acc + (r_acc[ACC_W-1] ? ACC_W'(ROUND_BIAS) : '0);
        w_q   = w_rnd >>> COEF_FRAC_BITS;
        if (w_q > ACC_W'(SAT_MAX)) begin
            w_sat = SAMPLE_W'(SAT_MAX);
        end else if (w_q < ACC_W'(SAT_MIN)) begin
            w_sat = SAMPLE_W'(SAT_MIN);
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (w_last_digit && w_last_tap) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_filter_select <= 1'b0;
            r_sel           <= 1'b0;
            r_tap           <= '0;
            r_digit         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_filter_select <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_sel   <= r_filter_select;
                r_tap   <= '0;
                r_digit <= '0;
            end else if (r_state == ST_MAC) begin
                r_digit <= r_digit + 1'b1;
                if (w_last_digit) begin
                    r_tap <= r_tap + 1'b1;
                end
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: multiplier shift register, accumulator, output beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc <= '0;
        end else if (r_state == ST_MAC) begin
            r_acc <= r_acc + w_term;
            r_mpy <= ((r_digit == '0) ? w_head : r_mpy) >>> DIGIT_W;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= w_sat;
        end
    end

    // History rings: push the new sample at accept, rotate once per tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LP_TAPS; i++) begin
                r_lp_ring[i] <= '0;
            end
            for (int i = 0; i < HP_TAPS; i++) begin
                r_hp_ring[i] <= '0;
            end
        end else if (w_accept) begin
            if (r_filter_select) begin
                r_hp_ring[0] <= s_tdata;
                for (int i = 1; i < HP_TAPS; i++) begin
                    r_hp_ring[i] <= r_hp_ring[i-1];
                end
            end else begin
                r_lp_ring[0] <= s_tdata;
                for (int i = 1; i < LP_TAPS; i++) begin
                    r_lp_ring[i] <= r_lp_ring[i-1];
                end
            end
        end else if (r_state == ST_MAC && w_last_digit) begin
            if (r_sel) begin
                for (int i = 0; i < HP_TAPS - 1; i++) begin
                    r_hp_ring[i] <= r_hp_ring[i+1];
                end
                r_hp_ring[HP_TAPS-1] <= r_hp_ring[0];
            end else begin
                for (int i = 0; i < LP_TAPS - 1; i++) begin
                    r_lp_ring[i] <= r_lp_ring[i+1];
                end
                r_lp_ring[LP_TAPS-1] <= r_lp_ring[0];
            end
        end
    end

`include "dual_mode_fir_filter_macros.svh"

    `DMF_ASSERT_NEXT(a_accept_starts_mac, w_accept, w_mac_first, "beat did not start a MAC pass")
    `DMF_ASSERT_IMPLY(a_tap_in_range, r_state == ST_MAC, r_tap <= w_tap_last, "tap overran")
    `DMF_ASSERT_IMPLY(a_out_done, $rose(r_out_valid), $past(r_state) == ST_DONE, "stray out beat")

endmodule

### tb/dual_mode_fir_filter_test.sv
// ----------------------------------------------------------------------------
// dual_mode_fir_filter_test
// Self-checking bench for the dual-mode (low-pass / high-pass) audio FIR.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream in random bursts while the master side
// stalls on its own pattern. Every accepted beat runs through a predictor
// of both filters (own histories, own write positions, Q1.15 taps) and the
// filtered sample, or a known table result, is queued and matched in order.
// A short directed table covers the sample rails, both filters from a cleared
// history and saturation, then random phases switch filters when idle.
// ----------------------------------------------------------------------------
module dual_mode_fir_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmf_pkg::SAMPLE_W;

    typedef enum bit {LOWPASS = 1'b0, HIGHPASS = 1'b1} t_filter_kind;
    typedef enum int {STYLE_UNIFORM, STYLE_RAILS, STYLE_QUIET, STYLE_MIXED} t_stim_style;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_HOLD} t_ready_mode;

    typedef struct packed {
        t_filter_kind        kind;
        logic [SAMPLE_W-1:0] sample;
        bit                  known;
        logic [SAMPLE_W-1:0] result;
    } t_stim_row;

    localparam int     LP_TAP_COUNT = 42;
    localparam int     HP_TAP_COUNT = 31;
    localparam longint Q15_ONE      = 32768;
    localparam longint OUT_MAX      = 32767;
    localparam longint OUT_MIN      = -32768;
    localparam int     RANDOM_ITEMS = 450;
    localparam int     TAIL_CYCLES  = 400;
    localparam int     CYCLE_LIMIT  = 1_200_000;
    localparam int     PRINT_LIMIT  = 200;

    localparam int LOWPASS_Q15 [LP_TAP_COUNT] = '{
        -224, -145, -174, -191, -190, -163, -105, -11, 123, 297, 511,
        758, 1033, 1325, 1623, 1913, 2182, 2416, 2604, 2734, 2802,
        2802, 2734, 2604, 2416, 2182, 1913, 1623, 1325, 1033, 758,
        511, 297, 123, -11, -105, -163, -190, -191, -174, -145, -224
    };

    localparam int HIGHPASS_Q15 [HP_TAP_COUNT] = '{
        -1657, 479, 568, 690, 788, 795, 651, 327, -185, -865, -1659,
        -2489, -3267, -3903, -4319, 28305,
        -4319, -3903, -3267, -2489, -1659, -865, -185, 327, 651, 795,
        788, 690, 568, 479, -1657
    };

    // High-pass rows line up rail values with the tap signs so the last
    // one drives the sum far past full scale.
    localparam int DIRECTED_COUNT = 23;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{LOWPASS,  16'h7FFF, 1'b1, 16'hFF21},
        '{LOWPASS,  16'h8000, 1'b0, 16'h0000},
        '{LOWPASS,  16'h0000, 1'b0, 16'h0000},
        '{LOWPASS,  16'h0001, 1'b0, 16'h0000},
        '{LOWPASS,  16'hFFFF, 1'b0, 16'h0000},
        '{LOWPASS,  16'h5555, 1'b0, 16'h0000},
        '{LOWPASS,  16'hAAAA, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b1, 16'hF988},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h7FFF, 1'b0, 16'h0000},
        '{HIGHPASS, 16'h8000, 1'b1, 16'h7FFF}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata     = '0;  // [15:0] mono_sample
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;           // [15:0] filtered_sample

    // Predictor state: one history and write position per filter
    logic signed [SAMPLE_W-1:0] history [2][LP_TAP_COUNT];
    int                         write_pos [2];
    t_filter_kind               active_filter = LOWPASS;

    logic [SAMPLE_W-1:0] expected_samples [$];
    bit                  row_known  = 1'b0;
    logic [SAMPLE_W-1:0] row_result = '0;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    logic [SAMPLE_W-1:0] rail_level = 16'h7FFF;
    int                  rail_left  = 0;
    t_ready_mode         ready_mode = READY_ALWAYS;
    int                  ready_left = 0;

    dual_mode_fir_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Store the sample, convolve newest-first, advance and wrap the position.
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
        longint acc;
        longint y;
        int     taps;
        int     pos;
        int     idx;
        int     k;
        int     coef;
        bit     hp;
        hp   = (active_filter == HIGHPASS);
        taps = hp ? HP_TAP_COUNT : LP_TAP_COUNT;
        pos  = write_pos[hp];
        history[hp][pos] = x;
        acc = 0;
        for (k = 0; k < taps; k++) begin
            idx  = (pos >= k) ? pos - k : pos + taps - k;
            coef = hp ? HIGHPASS_Q15[k] : LOWPASS_Q15[k];
            acc += longint'(history[hp][idx]) * longint'(coef);
        end
        write_pos[hp] = (pos + 1 == taps) ? 0 : pos + 1;
        y = acc / Q15_ONE;
        if (y > OUT_MAX) begin
            y = OUT_MAX;
        end else if (y < OUT_MIN) begin
            y = OUT_MIN;
        end
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_stim_style style);
        logic [SAMPLE_W-1:0] value;
        case (style)
            STYLE_UNIFORM: begin
                value = 16'($urandom);
            end
            STYLE_RAILS: begin
                // Hold a rail for a random run of 1 to 45 samples, which can fill a whole history
                if (rail_left == 0) begin
                    rail_level = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    rail_left  = $urandom_range(1, 45);
                end
                rail_left--;
                value = rail_level;
            end
            STYLE_QUIET: begin
                value = 16'($urandom_range(0, 64)) - 16'd32;
            end
            default: begin
                case ($urandom_range(0, 7))
                    0:       value = 16'h7FFF;
                    1:       value = 16'h8000;
                    2:       value = 16'h0000;
                    3:       value = 16'hFFFF;
                    default: value = 16'($urandom);
                endcase
            end
        endcase
        return value;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit known,
                               input logic [SAMPLE_W-1:0] result);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        row_known  <= known;
        row_result <= result;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Drain the pipe, then write the filter select while nothing is in flight.
    task automatic select_filter(input t_filter_kind kind);
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_samples.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kind;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        burst_left = 0;
    endtask

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = (ready_mode == READY_HOLD) ? $urandom_range(20, 300)
                                                    : $urandom_range(20, 400);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:      m_tready <= (ready_left == 0);
        endcase
    end

    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] expected;
        logic [SAMPLE_W-1:0] predicted;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT) begin
                        $display("%0t: filtered_sample expected none, got %0d",
                                 $time, $signed(m_tdata));
                    end
                end else begin
                    expected = expected_samples.pop_front();
                    if (m_tdata !== expected) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT) begin
                            $display("%0t: filtered_sample expected %0d, got %0d",
                                     $time, $signed(expected), $signed(m_tdata));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                active_filter = t_filter_kind'(i_cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                predicted = filter_sample(s_tdata);
                expected_samples.push_back(row_known ? row_result : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL dual_mode_fir_filter");
            $finish;
        end
    end

    initial begin
        int           row;
        int           sent;
        int           len;
        t_filter_kind kind;
        t_stim_style  style;
        for (row = 0; row < LP_TAP_COUNT; row++) begin
            history[0][row] = '0;
            history[1][row] = '0;
        end
        write_pos[0] = 0;
        write_pos[1] = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_COUNT; row++) begin
            if (row == 0 || DIRECTED_ROWS[row].kind != DIRECTED_ROWS[row-1].kind) begin
                select_filter(DIRECTED_ROWS[row].kind);
            end
            send_sample(DIRECTED_ROWS[row].sample, DIRECTED_ROWS[row].known,
                        DIRECTED_ROWS[row].result);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind  = t_filter_kind'($urandom_range(0, 1));
            style = t_stim_style'($urandom_range(0, 3));
            len   = $urandom_range(15, 60);
            if (len > RANDOM_ITEMS - sent) begin
                len = RANDOM_ITEMS - sent;
            end
            select_filter(kind);
            repeat (len) begin
                send_sample(pick_sample(style), 1'b0, '0);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASS dual_mode_fir_filter");
        end else begin
            $display("FAIL dual_mode_fir_filter");
        end
        $finish;
    end

endmodule
